>>> src/package_spec_field_splitter_assert.svh
// Assertion macros used by the splitter back end.
`ifndef PACKAGE_SPEC_FIELD_SPLITTER_ASSERT_SVH
`define PACKAGE_SPEC_FIELD_SPLITTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PSFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PSFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/psfs_pkg.sv
// Types, codes and constants of the package spec field splitter.
`timescale 1ns / 1ps
package psfs_pkg;

  localparam int MAX_LEN = 256;
  localparam int POS_W   = 9;
  localparam int NSLOT   = 5;
  localparam int NOFF    = 8;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 3;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    FORM_NEVRA = 3'd0,
    FORM_NEVR  = 3'd1,
    FORM_NEV   = 3'd2,
    FORM_NA    = 3'd3,
    FORM_NAME  = 3'd4,
    FORM_NONE  = 3'd5
  } form_t;

  typedef enum logic [2:0] {
    ST_MATCH   = 3'd0,
    ST_COLON   = 3'd1,
    ST_BADCHAR = 3'd2,
    ST_TOOLONG = 3'd3,
    ST_NOFIT   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_COLON   = 2'd1,
    ERR_BADCHAR = 2'd2,
    ERR_TOOLONG = 2'd3
  } err_t;

  typedef struct packed {
    logic             v;
    logic [POS_W-1:0] at;
  } mark_t;

  // One finished string as handed from front to back.
  typedef struct packed {
    mark_t            ld;
    mark_t            pd;
    mark_t            dt;
    mark_t            cl;
    logic [POS_W-1:0] n;
    err_t             err;
  } str_ent_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

>>> src/psfs_if.sv
// Request and result channel interfaces of the splitter.
`timescale 1ns / 1ps
interface psfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_valid;
  logic       end_of_string;

  modport source (output valid, char_code, char_valid, end_of_string, input ready);
  modport sink (input valid, char_code, char_valid, end_of_string, output ready);
endinterface

interface psfs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] form_code;
  logic [2:0] status;
  logic [8:0] name_end;
  logic [8:0] epoch_start;
  logic [8:0] epoch_end;
  logic [8:0] version_start;
  logic [8:0] version_end;
  logic [8:0] release_start;
  logic [8:0] release_end;
  logic [8:0] arch_start;
  logic [8:0] string_length;
  logic       last_result;

  modport source (output valid, form_code, status, name_end, epoch_start, epoch_end,
                  version_start, version_end, release_start, release_end, arch_start,
                  string_length, last_result, input ready);
  modport sink (input valid, form_code, status, name_end, epoch_start, epoch_end,
                version_start, version_end, release_start, release_end, arch_start,
                string_length, last_result, output ready);
endinterface

>>> src/psfs_front.sv
// Front end: per-character scan of delimiters, glob ranges and errors.
`timescale 1ns / 1ps
module psfs_front import psfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  psfs_in_if.sink     in_ch,
  input  q_stat_t     q_stat,
  output logic        push,
  output str_ent_t    push_ent
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             glob_r, glob_nxt;
  mark_t            ld_r, ld_nxt, pd_r, pd_nxt, dt_r, dt_nxt, cl_r, cl_nxt;
  err_t             err_r, err_nxt;
  logic             acc;
  logic [7:0]       c;

  assign in_ch.ready = !q_stat.full;
  assign acc = in_ch.valid && in_ch.ready;
  assign c   = in_ch.char_code;
  assign push = acc && in_ch.end_of_string;

  always_comb begin
    pos_nxt  = pos_r;
    glob_nxt = glob_r;
    ld_nxt   = ld_r;
    pd_nxt   = pd_r;
    dt_nxt   = dt_r;
    cl_nxt   = cl_r;
    err_nxt  = err_r;
    if (acc && in_ch.char_valid) begin
      if (pos_r >= POS_W'(MAX_LEN)) begin
        if (err_r == ERR_NONE) err_nxt = ERR_TOOLONG;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (err_r == ERR_NONE && !(glob_r && c != CH_RBRACK)) begin
          glob_nxt = 1'b0;
          if (c == CH_LBRACK) begin
            glob_nxt = 1'b1;
          end else if (c == CH_DASH) begin
            pd_nxt = ld_r;
            ld_nxt = '{v: 1'b1, at: pos_r};
          end else if (c == CH_DOT) begin
            dt_nxt = '{v: 1'b1, at: pos_r};
          end else if (c == CH_COLON) begin
            if (cl_r.v) err_nxt = ERR_COLON;
            else cl_nxt = '{v: 1'b1, at: pos_r};
          end else if (c == CH_LPAREN || c == CH_SLASH || c == CH_EQUAL ||
                       c == CH_LT || c == CH_GT || c == CH_SPACE) begin
            err_nxt = ERR_BADCHAR;
          end
        end
      end
    end
    push_ent = '{ld: ld_nxt, pd: pd_nxt, dt: dt_nxt, cl: cl_nxt, n: pos_nxt, err: err_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pos_r  <= '0;
      glob_r <= 1'b0;
      ld_r   <= '0;
      pd_r   <= '0;
      dt_r   <= '0;
      cl_r   <= '0;
      err_r  <= ERR_NONE;
    end else begin
      pos_r  <= pos_nxt;
      glob_r <= glob_nxt;
      ld_r   <= ld_nxt;
      pd_r   <= pd_nxt;
      dt_r   <= dt_nxt;
      cl_r   <= cl_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

>>> src/psfs_queue.sv
// Small queue of finished strings between front and back.
`timescale 1ns / 1ps
module psfs_queue import psfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  str_ent_t  push_ent,
  input  logic      pop,
  output str_ent_t  head,
  output q_stat_t   stat
);

  str_ent_t          ent_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head       = ent_r[rp_r];
  assign stat.valid = cnt_r != '0;
  assign stat.full  = cnt_r == QCNT_W'(QDEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_ent;
  end

endmodule

>>> src/psfs_back.sv
// Back end: form matching per slot and result emission.
`timescale 1ns / 1ps
module psfs_back import psfs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  str_ent_t             head,
  input  q_stat_t              q_stat,
  output logic                 pop,
  psfs_out_if.source           out_ch
);

  typedef logic signed [POS_W+1:0] sv_t;

  typedef struct packed {
    logic                      fit;
    logic [NOFF-1:0][POS_W-1:0] f;
  } tf_t;

  typedef struct packed {
    logic                   ok;
    logic [3:0][POS_W-1:0]  f;
  } ev_t;

  function automatic sv_t sx(logic [POS_W-1:0] x);
    return sv_t'({2'b00, x});
  endfunction

  function automatic ev_t split_ev(sv_t delim, sv_t lim, mark_t cl);
    ev_t r;
    sv_t s, c;
    s = delim + sv_t'(1);
    c = sx(cl.at);
    r.ok = 1'b1;
    r.f[0] = s[POS_W-1:0];
    r.f[1] = s[POS_W-1:0];
    if (cl.v) begin
      if (c - s < sv_t'(1) || lim - c < sv_t'(2)) r.ok = 1'b0;
      r.f[1] = c[POS_W-1:0];
      s = c + sv_t'(1);
    end
    if (lim - s < sv_t'(1)) r.ok = 1'b0;
    r.f[2] = s[POS_W-1:0];
    r.f[3] = lim[POS_W-1:0];
    return r;
  endfunction

  function automatic tf_t try_form(logic [2:0] form, str_ent_t e);
    tf_t r;
    ev_t ev;
    sv_t ld, pd, dt, n, t;
    ld = sx(e.ld.at);
    pd = sx(e.pd.at);
    dt = sx(e.dt.at);
    n  = sx(e.n);
    r.fit = 1'b0;
    for (int i = 0; i < NOFF; i++) r.f[i] = e.n;
    unique case (form)
      FORM_NEVRA, FORM_NEVR: begin
        r.fit = e.pd.v && e.ld.v && pd != sv_t'(0) && (form == FORM_NEVR || e.dt.v);
        r.f[0] = e.pd.at;
        ev = split_ev(pd, ld, e.cl);
        r.fit = r.fit && ev.ok;
        r.f[4:1] = ev.f;
        t = ld + sv_t'(1);
        r.f[5] = t[POS_W-1:0];
        if (form == FORM_NEVRA) begin
          r.fit = r.fit && (dt - t >= sv_t'(1)) && (n - dt - sv_t'(1) >= sv_t'(1));
          t = dt + sv_t'(1);
          r.f[6] = e.dt.at;
          r.f[7] = t[POS_W-1:0];
        end else begin
          r.fit = r.fit && (n - t >= sv_t'(1));
        end
      end
      FORM_NEV: begin
        ev = split_ev(ld, n, e.cl);
        r.fit = e.ld.v && ld != sv_t'(0) && ev.ok;
        r.f[0] = e.ld.at;
        r.f[4:1] = ev.f;
      end
      FORM_NA: begin
        r.fit = e.dt.v && !e.cl.v && dt != sv_t'(0) && !(e.ld.v && ld > dt) &&
                (n - dt != sv_t'(1));
        for (int i = 0; i < NOFF - 1; i++) r.f[i] = e.dt.at;
        t = dt + sv_t'(1);
        r.f[7] = t[POS_W-1:0];
      end
      FORM_NAME: r.fit = !e.cl.v && e.n != '0;
      default: r.fit = 1'b0;
    endcase
    return r;
  endfunction

  logic [2:0]       slot_r [NSLOT];
  logic             job_v_r;
  str_ent_t         job_r;
  logic [NSLOT-1:0] pend_r, pend_ld, sel, rest;
  status_t          stat_r, stat_ld;
  logic [7:0]       fits;
  logic             emit, job_last, job_ld;
  logic [2:0]       sel_form;
  tf_t              tf;
  tf_t              head_tf [NSLOT];

  logic             out_v_r;
  logic [2:0]       o_form_r;
  status_t          o_stat_r;
  logic [NOFF-1:0][POS_W-1:0] o_f_r;
  logic [POS_W-1:0] o_n_r;
  logic             o_last_r;

  always_comb begin
    fits = '0;
    for (int k = 0; k < NSLOT; k++) begin
      head_tf[k] = try_form(3'(k), head);
      fits[k] = head_tf[k].fit;
    end
    for (int i = 0; i < NSLOT; i++) pend_ld[i] = fits[slot_r[i]];
    if (head.err != ERR_NONE) begin
      pend_ld = '0;
      stat_ld = status_t'({1'b0, head.err});
    end else if (pend_ld == '0) begin
      stat_ld = ST_NOFIT;
    end else begin
      stat_ld = ST_MATCH;
    end
  end

  always_comb begin
    sel = pend_r & (~pend_r + 1'b1);
    rest = pend_r & ~sel;
    sel_form = slot_r[0];
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (sel[i]) sel_form = slot_r[i];
    end
    tf = try_form(sel_form, job_r);
  end

  assign emit     = job_v_r && (!out_v_r || out_ch.ready);
  assign job_last = emit && (stat_r != ST_MATCH || rest == '0);
  assign job_ld   = q_stat.valid && (!job_v_r || job_last);
  assign pop      = job_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r[0] <= FORM_NEVRA;
      slot_r[1] <= FORM_NA;
      slot_r[2] <= FORM_NAME;
      slot_r[3] <= FORM_NEVR;
      slot_r[4] <= FORM_NEV;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NSLOT)) begin
      slot_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (job_ld) job_v_r <= 1'b1;
      else if (job_last) job_v_r <= 1'b0;
      if (emit) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ld) begin
      job_r  <= head;
      pend_r <= pend_ld;
      stat_r <= stat_ld;
    end else if (emit) begin
      pend_r <= rest;
    end
    if (emit) begin
      o_n_r <= job_r.n;
      if (stat_r != ST_MATCH) begin
        o_form_r <= FORM_NEVRA;
        o_stat_r <= stat_r;
        o_f_r    <= '0;
        o_last_r <= 1'b1;
      end else begin
        o_form_r <= sel_form;
        o_stat_r <= ST_MATCH;
        o_f_r    <= tf.f;
        o_last_r <= rest == '0;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.form_code     = o_form_r;
  assign out_ch.status        = o_stat_r;
  assign out_ch.name_end      = o_f_r[0];
  assign out_ch.epoch_start   = o_f_r[1];
  assign out_ch.epoch_end     = o_f_r[2];
  assign out_ch.version_start = o_f_r[3];
  assign out_ch.version_end   = o_f_r[4];
  assign out_ch.release_start = o_f_r[5];
  assign out_ch.release_end   = o_f_r[6];
  assign out_ch.arch_start    = o_f_r[7];
  assign out_ch.string_length = o_n_r;
  assign out_ch.last_result   = o_last_r;

`include "package_spec_field_splitter_assert.svh"

  `PSFS_ASSERT_NOW(a_status_last, clk, rst_n, out_v_r && o_stat_r != ST_MATCH, o_last_r, "status result not last")
  `PSFS_ASSERT_NOW(a_match_pending, clk, rst_n, job_v_r && stat_r == ST_MATCH, pend_r != '0, "match job with nothing pending")
  `PSFS_ASSERT_NOW(a_match_form, clk, rst_n, out_v_r && o_stat_r == ST_MATCH, o_form_r <= FORM_NAME, "match with unused form code")

endmodule

>>> src/package_spec_field_splitter.sv
// Top level of the package spec field splitter.
// One character request is taken per cycle while the four-entry string queue has room.
// A string yields one result per fitting form slot (up to five) or a single status
// result, at one result per cycle from the output register while the sink is ready; the form checks of the
// next string overlap with the results of the current one. There is no clearing pass.
`timescale 1ns / 1ps
module package_spec_field_splitter import psfs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  psfs_in_if.sink              in_ch,
  psfs_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  q_stat_t  q_stat;
  logic     push, pop;
  str_ent_t push_ent, head;

  psfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_ent (push_ent)
  );

  psfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  psfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
